/* rtl/core/rfm_pkg.sv */
// Shared types and constants for the remote frame median filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rfm_pkg;

  localparam int AXIS_W       = 8;
  localparam int BTN_W        = 8;
  localparam int BUTTON_COUNT = 8;
  localparam int CODE_W       = 8;
  localparam int LIMIT_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int WINDOW_DEF   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_LIMIT = 1'd1;

  localparam logic [CODE_W-1:0]  START_CODE_RST = 8'd0;
  localparam logic [LIMIT_W-1:0] LOSS_LIMIT_RST = 16'd100;
  localparam logic [LIMIT_W-1:0] TICK_CNT_MAX   = 16'hFFFF;

  localparam logic [AXIS_W-1:0] AXIS_MAX_RAW = 8'd200;
  localparam logic [AXIS_W-1:0] AXIS_CENTRE  = 8'd100;

  localparam logic CMD_FRAME = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MED0,
    S_MERGE0,
    S_MERGE1,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/rfm_lane.sv */
// Median lane: rank test of one window entry against the whole window.
// Depends on rfm_pkg.
`default_nettype none
module rfm_lane #(
  parameter int WINDOW = rfm_pkg::WINDOW_DEF
) (
  input  logic signed [rfm_pkg::AXIS_W-1:0] cand_i,
  input  logic signed [rfm_pkg::AXIS_W-1:0] win_i [WINDOW],
  output logic                              qual_o
);
  import rfm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [CNT_W:0] higher;
  logic [CNT_W:0] lower;
  logic [CNT_W:0] same;

  always_comb begin
    higher = '0;
    lower  = '0;
    same   = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (cand_i < win_i[j]) begin
        higher = higher + (CNT_W+1)'(1);
      end else if (cand_i > win_i[j]) begin
        lower = lower + (CNT_W+1)'(1);
      end else begin
        same = same + (CNT_W+1)'(1);
      end
    end
    // |higher - lower| < same
    qual_o = (higher < lower + same) && (lower < higher + same);
  end

endmodule
`default_nettype wire

/* rtl/core/rfm_merge.sv */
// Merge stage: picks the lowest-slot entry whose lane qualified, else zero.
// Depends on rfm_pkg.
`default_nettype none
module rfm_merge #(
  parameter int WINDOW = rfm_pkg::WINDOW_DEF
) (
  input  logic [WINDOW-1:0]                 qual_i,
  input  logic signed [rfm_pkg::AXIS_W-1:0] win_i [WINDOW],
  output logic signed [rfm_pkg::AXIS_W-1:0] median_o
);
  import rfm_pkg::*;

  logic found;

  always_comb begin
    median_o = '0;
    found    = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      if (qual_i[i] && !found) begin
        median_o = win_i[i];
        found    = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/remote_frame_median_filter.sv */
// Remote frame median filter top level: history, control sequencer, lanes.
// Depends on rfm_pkg, rfm_lane, rfm_merge.
//
// Usage:
//   Input channel (in_*): one beat per received frame (command 0) or per
//   empty poll tick (command 1). Output channel (out_*): exactly one beat per
//   input beat, in order, carrying the held medians, voted buttons, a change
//   flag and the link status after that item.
//   Configuration (cfg_*): write start code (index 0) or loss limit (index 1)
//   while the block is idle.
// Timing:
//   History is written at the accept edge. An accepted frame with a matching
//   start byte while the link is not lost then passes lane ranking of axis 0,
//   ranking of axis 1 with merge of axis 0, merge of axis 1 with button vote,
//   and output load. Any other item goes straight to output load, which waits
//   while the output register holds a stalled beat. One item is in work at a
//   time; the next is taken the cycle after the output register is loaded.
//   The WINDOW lanes rank all entries of one axis in parallel per cycle.
// Reset: synchronous, clears history, counters, link flags, held values and
//   configuration (start code 0, loss limit 100).
// Stall: a finished result waits in the output register; a following item
//   is still accepted and waits before its output load until that beat goes.
`default_nettype none
module remote_frame_median_filter #(
  parameter int WINDOW = rfm_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [7:0]                           in_lead_byte,
  input  logic [7:0]                           in_left_axis_byte,
  input  logic [7:0]                           in_right_axis_byte,
  input  logic [7:0]                           in_face_button_byte,
  input  logic [7:0]                           in_shoulder_button_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rfm_pkg::AXIS_W-1:0]    out_left_axis_median,
  output logic signed [rfm_pkg::AXIS_W-1:0]    out_right_axis_median,
  output logic [rfm_pkg::BTN_W-1:0]            out_button_states,
  output logic                                 out_values_changed,
  output logic                                 out_link_active
);
  import rfm_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  state_t state_r, state_nxt;

  logic [CODE_W-1:0]  start_code_r;
  logic [LIMIT_W-1:0] loss_limit_r;

  logic signed [AXIS_W-1:0] left_hist_r  [WINDOW];
  logic signed [AXIS_W-1:0] right_hist_r [WINDOW];
  logic [WINDOW-1:0]        btn_hist_r   [BUTTON_COUNT];
  logic [SLOT_W-1:0]        slot_r;
  logic [LIMIT_W-1:0]       tick_cnt_r;
  logic                     lost_r;
  logic                     ever_r;

  logic signed [AXIS_W-1:0] held_left_r;
  logic signed [AXIS_W-1:0] held_right_r;
  logic [BTN_W-1:0]         held_btn_r;
  logic signed [AXIS_W-1:0] med_left_r;
  logic                     changed_r;
  logic [WINDOW-1:0]        qual_r;

  logic                     out_valid_r;
  logic signed [AXIS_W-1:0] out_left_r;
  logic signed [AXIS_W-1:0] out_right_r;
  logic [BTN_W-1:0]         out_btn_r;
  logic                     out_chg_r;
  logic                     out_act_r;

  logic               in_acc;
  logic               frame;
  logic               live;
  logic               good;
  logic               tick;
  logic               lose;
  logic [LIMIT_W-1:0] tick_cnt_inc;
  logic               out_free;
  logic [BUTTON_COUNT-1:0] btn_new;
  logic [BUTTON_COUNT-1:0] btn_vote;
  logic [CNT_W:0]          btn_cnt [BUTTON_COUNT];

  logic signed [AXIS_W-1:0] lane_win  [WINDOW];
  logic signed [AXIS_W-1:0] merge_win [WINDOW];
  logic [WINDOW-1:0]        lane_qual;
  logic signed [AXIS_W-1:0] merge_med;
  logic                     med_chg;

  // Accept-time decode
  always_comb begin
    in_acc       = in_valid && !in_stall;
    frame        = (in_command == CMD_FRAME);
    live         = !lost_r && (ever_r || frame);
    good         = live && frame && (in_lead_byte == start_code_r);
    tick         = live && !frame;
    tick_cnt_inc = (tick_cnt_r == TICK_CNT_MAX) ? tick_cnt_r : tick_cnt_r + LIMIT_W'(1);
    lose         = tick && (tick_cnt_inc > loss_limit_r);
    out_free     = !out_valid_r || !out_stall;
    for (int k = 0; k < 4; k++) begin
      btn_new[k]     = in_face_button_byte[7-2*k] & ~in_face_button_byte[6-2*k];
      btn_new[k + 4] = in_shoulder_button_byte[7-2*k] & ~in_shoulder_button_byte[6-2*k];
    end
  end

  // Lanes rank axis 0 in S_MED0, axis 1 in S_MERGE0
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      lane_win[i]  = (state_r == S_MERGE0) ? right_hist_r[i] : left_hist_r[i];
      merge_win[i] = (state_r == S_MERGE1) ? right_hist_r[i] : left_hist_r[i];
    end
  end

  for (genvar gi = 0; gi < WINDOW; gi++) begin : g_lane
    rfm_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .cand_i (lane_win[gi]),
      .win_i  (lane_win),
      .qual_o (lane_qual[gi])
    );
  end

  rfm_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .qual_i   (qual_r),
    .win_i    (merge_win),
    .median_o (merge_med)
  );

  // Button majority
  always_comb begin
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      btn_cnt[b] = '0;
      for (int i = 0; i < WINDOW; i++) begin
        btn_cnt[b] = btn_cnt[b] + (CNT_W+1)'(btn_hist_r[b][i]);
      end
      btn_vote[b] = ({btn_cnt[b], 1'b0} > (CNT_W+2)'(WINDOW));
    end
    med_chg = (med_left_r != held_left_r) || (merge_med != held_right_r) ||
              (btn_vote != held_btn_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = good ? S_MED0 : S_OUT;
        end
      end
      S_MED0:   state_nxt = S_MERGE0;
      S_MERGE0: state_nxt = S_MERGE1;
      S_MERGE1: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_code_r <= START_CODE_RST;
      loss_limit_r <= LOSS_LIMIT_RST;
      for (int i = 0; i < WINDOW; i++) begin
        left_hist_r[i]  <= '0;
        right_hist_r[i] <= '0;
      end
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        btn_hist_r[b] <= '0;
      end
      slot_r       <= '0;
      tick_cnt_r   <= '0;
      lost_r       <= 1'b0;
      ever_r       <= 1'b0;
      held_left_r  <= '0;
      held_right_r <= '0;
      held_btn_r   <= '0;
      changed_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_START_CODE: start_code_r <= cfg_data[CODE_W-1:0];
          CFG_LOSS_LIMIT: loss_limit_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        changed_r <= 1'b0;
        if (live) begin
          ever_r <= 1'b1;
        end
        if (good) begin
          tick_cnt_r <= '0;
          if (in_left_axis_byte <= AXIS_MAX_RAW) begin
            left_hist_r[slot_r] <= in_left_axis_byte - AXIS_CENTRE;
          end
          if (in_right_axis_byte <= AXIS_MAX_RAW) begin
            right_hist_r[slot_r] <= in_right_axis_byte - AXIS_CENTRE;
          end
          for (int b = 0; b < BUTTON_COUNT; b++) begin
            btn_hist_r[b][slot_r] <= btn_new[b];
          end
          slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
        end
        if (tick) begin
          tick_cnt_r <= tick_cnt_inc;
        end
        if (lose) begin
          lost_r <= 1'b1;
          for (int i = 0; i < WINDOW; i++) begin
            left_hist_r[i]  <= '0;
            right_hist_r[i] <= '0;
          end
          for (int b = 0; b < BUTTON_COUNT; b++) begin
            btn_hist_r[b] <= '0;
          end
        end
      end

      if (state_r == S_MERGE1) begin
        held_left_r  <= med_left_r;
        held_right_r <= merge_med;
        held_btn_r   <= btn_vote;
        changed_r    <= med_chg;
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_MED0 || state_r == S_MERGE0) begin
      qual_r <= lane_qual;
    end
    if (state_r == S_MERGE0) begin
      med_left_r <= merge_med;
    end
    if (state_r == S_OUT && out_free) begin
      out_left_r  <= held_left_r;
      out_right_r <= held_right_r;
      out_btn_r   <= held_btn_r;
      out_chg_r   <= changed_r;
      out_act_r   <= ever_r && !lost_r;
    end
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_left_axis_median  = out_left_r;
  assign out_right_axis_median = out_right_r;
  assign out_button_states     = out_btn_r;
  assign out_values_changed    = out_chg_r;
  assign out_link_active       = out_act_r;

  a_lost_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r |-> ever_r)
    else $error("link lost without ever connecting");

  a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r |=> lost_r)
    else $error("link lost flag cleared outside reset");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("write slot beyond window");

  a_no_change_when_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_act_r) |-> !out_chg_r)
    else $error("change reported while link inactive");

endmodule
`default_nettype wire

/* bench/filter_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the remote frame median filter bench: a bit-true model of the
// window history, link state and held outputs, plus the queue of expected beats.
// Depends on rfm_pkg.
package filter_scoreboard_pkg;
  import rfm_pkg::*;

  localparam int WINDOW = WINDOW_DEF;
  localparam int AXES   = 2;

  typedef struct {
    bit signed [AXIS_W-1:0] left_median;
    bit signed [AXIS_W-1:0] right_median;
    bit [BTN_W-1:0]         buttons;
    bit                     changed;
    bit                     active;
  } filtered_beat_t;

  class filter_scoreboard;
    bit [CODE_W-1:0]        start_code;
    bit [LIMIT_W-1:0]       loss_limit;
    bit signed [AXIS_W-1:0] axis_hist [AXES][WINDOW];
    bit                     button_hist [BUTTON_COUNT][WINDOW];
    int                     slot;
    bit [LIMIT_W-1:0]       tick_count;
    bit                     link_lost;
    bit                     connected;
    bit signed [AXIS_W-1:0] held_axis [AXES];
    bit [BTN_W-1:0]         held_buttons;
    filtered_beat_t         expected_beats[$];
    int                     beat_count;
    int                     errors;

    function new();
      start_code   = START_CODE_RST;
      loss_limit   = LOSS_LIMIT_RST;
      clear_history();
      slot         = 0;
      tick_count   = '0;
      link_lost    = 1'b0;
      connected    = 1'b0;
      held_axis[0] = '0;
      held_axis[1] = '0;
      held_buttons = '0;
      beat_count   = 0;
      errors       = 0;
    endfunction

    function void clear_history();
      foreach (axis_hist[a, i]) axis_hist[a][i] = '0;
      foreach (button_hist[b, i]) button_hist[b][i] = 1'b0;
    endfunction

    // first entry, scanning from slot 0, whose rank balance fits its multiplicity
    function bit signed [AXIS_W-1:0] window_median(int axis);
      int higher, lower, same, diff;
      for (int i = 0; i < WINDOW; i++) begin
        higher = 0;
        lower  = 0;
        same   = 0;
        for (int j = 0; j < WINDOW; j++) begin
          if (axis_hist[axis][i] < axis_hist[axis][j]) higher++;
          else if (axis_hist[axis][i] > axis_hist[axis][j]) lower++;
          else same++;
        end
        diff = higher - lower;
        if (diff < 0) diff = -diff;
        if (diff < same) return axis_hist[axis][i];
      end
      return '0;
    endfunction

    function bit majority(int b);
      int pressed;
      pressed = 0;
      for (int i = 0; i < WINDOW; i++) if (button_hist[b][i]) pressed++;
      return pressed > WINDOW - pressed;
    endfunction

    task report(string msg);
      $display("ERROR beat %0d: %s", beat_count, msg);
      errors++;
    endtask

    function void configure(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] value);
      case (index)
        CFG_START_CODE: start_code = value[CODE_W-1:0];
        CFG_LOSS_LIMIT: loss_limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(bit cmd, bit [7:0] lead, bit [7:0] left_byte,
                            bit [7:0] right_byte, bit [7:0] face, bit [7:0] shoulder);
      filtered_beat_t         beat;
      bit                     changed;
      bit [7:0]               raw [AXES];
      bit [BTN_W-1:0]         votes;
      bit signed [AXIS_W-1:0] med;
      changed = 1'b0;
      raw[0]  = left_byte;
      raw[1]  = right_byte;
      if (!link_lost && (connected || cmd == CMD_FRAME)) begin
        connected = 1'b1;
        if (cmd == CMD_FRAME) begin
          if (lead == start_code) begin
            tick_count = '0;
            for (int a = 0; a < AXES; a++)
              if (raw[a] <= AXIS_MAX_RAW) axis_hist[a][slot] = raw[a] - AXIS_CENTRE;
            for (int k = 0; k < 4; k++) begin
              button_hist[k][slot]     = face[7-2*k] & ~face[6-2*k];
              button_hist[k + 4][slot] = shoulder[7-2*k] & ~shoulder[6-2*k];
            end
            slot = (slot + 1) % WINDOW;
            for (int a = 0; a < AXES; a++) begin
              med = window_median(a);
              if (med != held_axis[a]) begin
                held_axis[a] = med;
                changed      = 1'b1;
              end
            end
            for (int b = 0; b < BUTTON_COUNT; b++) votes[b] = majority(b);
            if (votes != held_buttons) begin
              held_buttons = votes;
              changed      = 1'b1;
            end
          end
        end else begin
          if (tick_count != TICK_CNT_MAX) tick_count++;
          if (tick_count > loss_limit) begin
            clear_history();
            link_lost = 1'b1;
          end
        end
      end
      beat.left_median  = held_axis[0];
      beat.right_median = held_axis[1];
      beat.buttons      = held_buttons;
      beat.changed      = changed;
      beat.active       = connected && !link_lost;
      expected_beats.push_back(beat);
    endfunction

    task check_beat(logic signed [AXIS_W-1:0] left, logic signed [AXIS_W-1:0] right,
                    logic [BTN_W-1:0] buttons, logic changed, logic active);
      filtered_beat_t want;
      if (expected_beats.size() == 0) begin
        report("output beat with no input pending");
        beat_count++;
        return;
      end
      want = expected_beats.pop_front();
      if (left !== want.left_median)
        report($sformatf("left_axis_median %0d, expected %0d", left, want.left_median));
      if (right !== want.right_median)
        report($sformatf("right_axis_median %0d, expected %0d", right, want.right_median));
      if (buttons !== want.buttons)
        report($sformatf("button_states %h, expected %h", buttons, want.buttons));
      if (changed !== want.changed)
        report($sformatf("values_changed %b, expected %b", changed, want.changed));
      if (active !== want.active)
        report($sformatf("link_active %b, expected %b", active, want.active));
      beat_count++;
    endtask
  endclass

endpackage

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top-level bench for remote_frame_median_filter: directed and random frames
// and poll ticks under random pacing and output stall, every beat checked.
// Depends on rfm_pkg, filter_scoreboard_pkg and the DUT.
module tb;
  import rfm_pkg::*;
  import filter_scoreboard_pkg::*;

  localparam logic CMD_TICK         = ~CMD_FRAME;
  localparam int   CYCLE_LIMIT      = 1_500_000;
  localparam int   RANDOM_PHASES    = 8;
  localparam int   PHASE_ITEMS      = 150;
  localparam int   DRAIN_CYCLES     = 20;

  typedef struct {
    bit       cmd;
    bit [7:0] lead;
    bit [7:0] left_byte;
    bit [7:0] right_byte;
    bit [7:0] face;
    bit [7:0] shoulder;
  } frame_item_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_command = 1'b0;
  logic [7:0]                    in_lead_byte = '0;
  logic [7:0]                    in_left_axis_byte = '0;
  logic [7:0]                    in_right_axis_byte = '0;
  logic [7:0]                    in_face_button_byte = '0;
  logic [7:0]                    in_shoulder_button_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [AXIS_W-1:0]      out_left_axis_median;
  logic signed [AXIS_W-1:0]      out_right_axis_median;
  logic [BTN_W-1:0]              out_button_states;
  logic                          out_values_changed;
  logic                          out_link_active;

  filter_scoreboard sb;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int burst_left = 0;
  int stall_run = 0;
  bit stall_now = 1'b0;

  remote_frame_median_filter dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_lead_byte            (in_lead_byte),
    .in_left_axis_byte       (in_left_axis_byte),
    .in_right_axis_byte      (in_right_axis_byte),
    .in_face_button_byte     (in_face_button_byte),
    .in_shoulder_button_byte (in_shoulder_button_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_left_axis_median    (out_left_axis_median),
    .out_right_axis_median   (out_right_axis_median),
    .out_button_states       (out_button_states),
    .out_values_changed      (out_values_changed),
    .out_link_active         (out_link_active)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // receiver: alternating stall and free runs of random length
  always @(posedge clk) begin
    if (stall_run <= 0) begin
      stall_now = !stall_now;
      stall_run = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 30);
    end
    stall_run--;
    out_stall <= stall_now && !quiet;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_left_axis_median, out_right_axis_median, out_button_states,
                    out_values_changed, out_link_active);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  task automatic send_item(frame_item_t it);
    in_valid                <= 1'b1;
    in_command              <= it.cmd;
    in_lead_byte            <= it.lead;
    in_left_axis_byte       <= it.left_byte;
    in_right_axis_byte      <= it.right_byte;
    in_face_button_byte     <= it.face;
    in_shoulder_button_byte <= it.shoulder;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it.cmd, it.lead, it.left_byte, it.right_byte, it.face, it.shoulder);
  endtask

  // sender: bursts of beats separated by idle gaps
  task automatic paced_send(frame_item_t it);
    if (!quiet && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    send_item(it);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(bit [CODE_W-1:0] code, bit [LIMIT_W-1:0] limit);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_CODE;
    cfg_data  <= CFG_DATA_W'(code);
    @(posedge clk);
    cfg_index <= CFG_LOSS_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    sb.configure(CFG_START_CODE, CFG_DATA_W'(code));
    sb.configure(CFG_LOSS_LIMIT, limit);
  endtask

  function automatic frame_item_t make_item(bit cmd, bit [7:0] lead, bit [7:0] left_byte,
                                            bit [7:0] right_byte, bit [7:0] face,
                                            bit [7:0] shoulder);
    frame_item_t it;
    it.cmd        = cmd;
    it.lead       = lead;
    it.left_byte  = left_byte;
    it.right_byte = right_byte;
    it.face       = face;
    it.shoulder   = shoulder;
    return it;
  endfunction

  // narrow values make duplicates in the window, a few are out of range
  function automatic bit [7:0] axis_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'($urandom_range(201, 255));
    if (roll < 5) return 8'($urandom_range(97, 103));
    return 8'($urandom_range(0, 200));
  endfunction

  // mostly good frames; ticks only while the link cannot be lost
  function automatic frame_item_t pick_item();
    frame_item_t it;
    int roll;
    roll          = $urandom_range(0, 99);
    it.cmd        = CMD_FRAME;
    it.lead       = sb.start_code;
    it.left_byte  = axis_byte();
    it.right_byte = axis_byte();
    it.face       = 8'($urandom);
    it.shoulder   = 8'($urandom);
    if (roll < 20 && sb.tick_count < sb.loss_limit) begin
      it.cmd = CMD_TICK;
    end else if (roll >= 88 && roll < 95) begin
      it.lead = sb.start_code ^ 8'($urandom_range(1, 255));
    end else if (roll >= 95) begin
      it.lead       = 8'($urandom);
      it.left_byte  = 8'($urandom);
      it.right_byte = 8'($urandom);
    end
    return it;
  endfunction

  initial begin
    frame_item_t      directed[$];
    frame_item_t      it;
    bit [CODE_W-1:0]  code;
    bit [LIMIT_W-1:0] limit;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks before the first frame, bad lead, axis extremes, ties and majorities
    directed.push_back(make_item(CMD_TICK,  8'h00, 8'd100, 8'd100, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_TICK,  8'h00, 8'd100, 8'd100, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h5A, 8'd0,   8'd200, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_TICK,  8'h00, 8'd0,   8'd0,   8'h00, 8'h00));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd0,   8'd200, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd200, 8'd0,   8'hFF, 8'h00));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd201, 8'd255, 8'h55, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd100, 8'd100, 8'hAA, 8'h55));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd255, 8'd201, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd0,   8'd0,   8'h00, 8'h00));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd150, 8'd50,  8'hA8, 8'h2A));
    directed.push_back(make_item(CMD_FRAME, 8'hFF, 8'd200, 8'd200, 8'hFF, 8'hFF));
    directed.push_back(make_item(CMD_TICK,  8'hFF, 8'd255, 8'd255, 8'hFF, 8'hFF));
    directed.push_back(make_item(CMD_TICK,  8'h00, 8'd0,   8'd0,   8'h00, 8'h00));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd200, 8'd200, 8'hFF, 8'hFF));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd99,  8'd101, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd99,  8'd101, 8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd101, 8'd99,  8'hAA, 8'hAA));
    directed.push_back(make_item(CMD_FRAME, 8'h00, 8'd101, 8'd99,  8'h80, 8'h02));
    foreach (directed[i]) paced_send(directed[i]);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      code  = 8'($urandom);
      limit = 16'd8;
      case (p)
        0: begin code = 8'hFF; limit = 16'hFFFF; end
        1: begin code = 8'h00; limit = 16'd1; end
        2: limit = 16'd5;
        3: limit = 16'd12;
        4: limit = 16'($urandom_range(20, 400));
        5: begin code = 8'hA5; limit = LOSS_LIMIT_RST; end
        6: limit = 16'd3;
        default: ;
      endcase
      set_config(code, limit);
      quiet = (p == 2);
      repeat (PHASE_ITEMS) paced_send(pick_item());
    end
    quiet = 1'b0;

    // zero limit: one tick after a good frame drops the link, then all is ignored
    set_config(8'($urandom), 16'd0);
    it      = pick_item();
    it.cmd  = CMD_FRAME;
    it.lead = sb.start_code;
    paced_send(it);
    it.cmd = CMD_TICK;
    paced_send(it);
    repeat (12) begin
      it     = pick_item();
      it.cmd = 1'($urandom);
      paced_send(it);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rfm_pkg.sv
rtl/core/rfm_lane.sv
rtl/core/rfm_merge.sv
rtl/core/remote_frame_median_filter.sv
bench/filter_scoreboard_pkg.sv
bench/tb.sv
